>>> rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants of the UV sphere tessellator.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF = 8;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;

  // sine unit pipeline depth
  localparam int unsigned SIN_LAT = 6;

  // Q16 Taylor coefficients of sin(pi/2*x), highest order first
  localparam logic [16:0] SIN_C4 = 17'd11;
  localparam logic [16:0] SIN_C3 = 17'd307;
  localparam logic [16:0] SIN_C2 = 17'd5223;
  localparam logic [16:0] SIN_C1 = 17'd42334;
  localparam logic [16:0] SIN_C0 = 17'd102944;
  localparam logic [16:0] SIN_ONE = 17'd65536;

  localparam logic [15:0] RADIUS_RST  = 16'd256;
  localparam logic [7:0]  STACKS_RST  = 8'd18;
  localparam logic [7:0]  SECTORS_RST = 8'd36;

  typedef enum logic [1:0] {
    CFG_RADIUS  = 2'd0,
    CFG_STACKS  = 2'd1,
    CFG_SECTORS = 2'd2
  } cfg_idx_e;

  // per-item sideband that does not depend on the angles
  typedef struct packed {
    logic        grid;
    logic        has_tri;
    logic [15:0] a0;
    logic [15:0] a1;
    logic [15:0] a2;
    logic [15:0] b0;
    logic [15:0] b1;
    logic [15:0] b2;
  } mesh_t;

endpackage

>>> rtl/uv_sphere_tessellator.sv
// ----------------------------------------------------------------------------
// uv_sphere_tessellator
// Path: the front queue, the bit-per-stage angle dividers, the sine
// pipelines, the product registers and the output register.
// Throughput: one grid point per cycle; the back pipeline stalls as a whole
// only while the output register holds a beat that is not taken.
// Reset: asynchronous, clears all valid flags and the queue; radius = 256,
// stacks = 18, sectors = 36. No clearing pass.
// ----------------------------------------------------------------------------
module uv_sphere_tessellator import uvs_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,  // stack_index[7:0], sector_index[15:8]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[16:0], pos_y[33:17], pos_z[50:34], tri_a0[66:51], tri_a1[82:67],
  // tri_a2[98:83], tri_b0[114:99], tri_b1[130:115], tri_b2[146:131], zeros
  output logic [151:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // in_grid[0], cell_valid[1]
);

  localparam int unsigned NUM_W = COUNT_BITS + ANGLE_BITS + 2;
  localparam int unsigned DEN_W = COUNT_BITS + 2;

  logic [15:0] radius_q;
  logic [7:0]  stacks_q, sectors_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RADIUS_RST;
      stacks_q  <= STACKS_RST;
      sectors_q <= SECTORS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RADIUS:  radius_q  <= cfg_wdata_i;
        CFG_STACKS:  stacks_q  <= cfg_wdata_i[7:0];
        CFG_SECTORS: sectors_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  logic             deq_valid, pop;
  mesh_t            deq_mesh, out_mesh;
  logic [NUM_W-1:0] num_phi, num_th;
  logic [DEN_W-1:0] den_phi, den_th;
  logic [16:0]      pos_x, pos_y, pos_z;

  uvs_front #(
    .ANGLE_BITS(ANGLE_BITS), .COUNT_BITS(COUNT_BITS), .NUM_W(NUM_W), .DEN_W(DEN_W)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .stack_index_i  (s_axis_tdata[7:0]),
    .sector_index_i (s_axis_tdata[15:8]),
    .stack_count_i  (stacks_q),
    .sector_count_i (sectors_q),
    .pop_i          (pop),
    .deq_valid_o    (deq_valid),
    .deq_mesh_o     (deq_mesh),
    .deq_num_phi_o  (num_phi),
    .deq_den_phi_o  (den_phi),
    .deq_num_th_o   (num_th),
    .deq_den_th_o   (den_th)
  );

  uvs_back #(
    .ANGLE_BITS(ANGLE_BITS), .COUNT_BITS(COUNT_BITS), .NUM_W(NUM_W), .DEN_W(DEN_W)
  ) u_back (
    .clk_i,
    .rst_ni,
    .deq_valid_i (deq_valid),
    .pop_o       (pop),
    .deq_mesh_i  (deq_mesh),
    .num_phi_i   (num_phi),
    .den_phi_i   (den_phi),
    .num_th_i    (num_th),
    .den_th_i    (den_th),
    .radius_i    (radius_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y),
    .pos_z_o     (pos_z),
    .out_mesh_o  (out_mesh)
  );

  assign m_axis_tdata = {5'd0, out_mesh.b2, out_mesh.b1, out_mesh.b0,
                         out_mesh.a2, out_mesh.a1, out_mesh.a0,
                         pos_z, pos_y, pos_x};
  assign m_axis_tuser = {out_mesh.has_tri, out_mesh.grid};

endmodule

>>> rtl/uvs_front.sv
// ----------------------------------------------------------------------------
// uvs_front
// Accepts grid points, classifies them, builds triangle indices and the
// angle division operands, and queues them for the back end.
// ----------------------------------------------------------------------------
module uvs_front import uvs_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned NUM_W      = COUNT_BITS + ANGLE_BITS + 2,
  parameter int unsigned DEN_W      = COUNT_BITS + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       stack_index_i,
  input  logic [7:0]       sector_index_i,
  input  logic [7:0]       stack_count_i,
  input  logic [7:0]       sector_count_i,
  input  logic             pop_i,
  output logic             deq_valid_o,
  output mesh_t            deq_mesh_o,
  output logic [NUM_W-1:0] deq_num_phi_o,
  output logic [DEN_W-1:0] deq_den_phi_o,
  output logic [NUM_W-1:0] deq_num_th_o,
  output logic [DEN_W-1:0] deq_den_th_o
);

  logic [COUNT_BITS-1:0] idx_i, idx_j, s_raw, n_raw, s_cnt, n_cnt;
  logic [COUNT_BITS:0]   row;
  logic [15:0]           here, below;
  logic                  grid, has_tri;
  mesh_t                 mesh;
  logic [NUM_W-1:0]      num_phi, num_th;
  logic [DEN_W-1:0]      den_phi, den_th;

  always_comb begin
    idx_i = COUNT_BITS'(stack_index_i);
    idx_j = COUNT_BITS'(sector_index_i);
    s_raw = COUNT_BITS'(stack_count_i);
    n_raw = COUNT_BITS'(sector_count_i);
    // zero count acts as one
    s_cnt = (s_raw == '0) ? COUNT_BITS'(1) : s_raw;
    n_cnt = (n_raw == '0) ? COUNT_BITS'(1) : n_raw;
    grid    = (idx_i <= s_cnt) && (idx_j <= n_cnt);
    has_tri = (idx_i < s_cnt) && (idx_j < n_cnt);
    row   = (COUNT_BITS + 1)'(n_cnt) + (COUNT_BITS + 1)'(1);
    here  = 16'(16'(idx_i) * 16'(row)) + 16'(idx_j);
    below = here + 16'(row);

    mesh.grid    = grid;
    mesh.has_tri = has_tri;
    mesh.a0   = has_tri ? below : 16'd0;
    mesh.a1   = has_tri ? here : 16'd0;
    mesh.a2   = has_tri ? here + 16'd1 : 16'd0;
    mesh.b0   = has_tri ? below : 16'd0;
    mesh.b1   = has_tri ? below + 16'd1 : 16'd0;
    mesh.b2   = has_tri ? here + 16'd1 : 16'd0;

    // phi offset = (2*i*FULL + s) / (4*s), theta = (2*j*FULL + n) / (2*n)
    num_phi = (NUM_W'(idx_i) << (ANGLE_BITS + 1)) + NUM_W'(s_cnt);
    den_phi = DEN_W'(s_cnt) << 2;
    num_th  = (NUM_W'(idx_j) << (ANGLE_BITS + 1)) + NUM_W'(n_cnt);
    den_th  = DEN_W'(n_cnt) << 1;
  end

  // small queue
  mesh_t            q_mesh_q    [QDEPTH];
  logic [NUM_W-1:0] q_num_phi_q [QDEPTH];
  logic [DEN_W-1:0] q_den_phi_q [QDEPTH];
  logic [NUM_W-1:0] q_num_th_q  [QDEPTH];
  logic [DEN_W-1:0] q_den_th_q  [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != (QPTR_W + 1)'(QDEPTH));
  assign deq_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = pop_i && deq_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mesh_q[wr_ptr_q]    <= mesh;
      q_num_phi_q[wr_ptr_q] <= num_phi;
      q_den_phi_q[wr_ptr_q] <= den_phi;
      q_num_th_q[wr_ptr_q]  <= num_th;
      q_den_th_q[wr_ptr_q]  <= den_th;
    end
  end

  assign deq_mesh_o    = q_mesh_q[rd_ptr_q];
  assign deq_num_phi_o = q_num_phi_q[rd_ptr_q];
  assign deq_den_phi_o = q_den_phi_q[rd_ptr_q];
  assign deq_num_th_o  = q_num_th_q[rd_ptr_q];
  assign deq_den_th_o  = q_den_th_q[rd_ptr_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W + 1)'(QDEPTH))
    else $error("queue count above depth");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> cnt_q != '0)
    else $error("queue empty after push");

endmodule

>>> rtl/uvs_div.sv
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module uvs_div import uvs_pkg::*; #(
  parameter int unsigned QB    = ANGLE_BITS_DEF + 1,
  parameter int unsigned NUM_W = COUNT_BITS_DEF + ANGLE_BITS_DEF + 2,
  parameter int unsigned DEN_W = COUNT_BITS_DEF + 2
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QB-1:0]    quo_o
);

  logic [DEN_W-1:0] rem_q [QB];
  logic [QB-1:0]    low_q [QB];
  logic [QB-1:0]    quo_q [QB];
  logic [DEN_W-1:0] den_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in, den_in, rem_out;
    logic [QB-1:0]    low_in, quo_in, quo_out;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = DEN_W'(num_i >> QB);
      assign low_in = num_i[QB-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      trial   = {rem_in, low_in[QB-1-k]};
      ge      = (trial >= {1'b0, den_in});
      rem_out = ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
      quo_out = quo_in;
      quo_out[QB-1-k] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_out;
        low_q[k] <= low_in;
        quo_q[k] <= quo_out;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

>>> rtl/uvs_sin.sv
// ----------------------------------------------------------------------------
// uvs_sin
// Fixed-point sine: quadrant fold, then a Horner polynomial, one multiply
// per stage.
// ----------------------------------------------------------------------------
module uvs_sin import uvs_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [ANGLE_BITS-1:0] ang_i,
  output logic signed [17:0]    sin_o
);

  localparam int unsigned PW = ANGLE_BITS + 16;

  function automatic logic [16:0] horner(input logic [16:0] c, input logic [16:0] t,
                                         input logic [16:0] x2);
    logic [33:0] p;
    p = 34'(t) * 34'(x2);
    return c - 17'(p >> 16);
  endfunction

  logic [ANGLE_BITS-3:0] frac;
  logic [PW-1:0]         wide;
  logic [16:0]           x0;
  logic [33:0]           sq, fin;
  logic [16:0]           mag;

  logic [1:0]  q_q  [SIN_LAT-1];
  logic [16:0] x_q  [SIN_LAT-1];
  logic [16:0] x2_q [SIN_LAT-1];
  logic [16:0] t_q  [SIN_LAT-1];
  logic signed [17:0] res_q;

  always_comb begin
    frac = ang_i[ANGLE_BITS-3:0];
    wide = (PW'(frac) << 18) >> ANGLE_BITS;
    x0   = 17'(wide);
    if (ang_i[ANGLE_BITS-2]) x0 = SIN_ONE - x0;
    sq   = 34'(x0) * 34'(x0);
    fin  = 34'(t_q[SIN_LAT-2]) * 34'(x_q[SIN_LAT-2]);
    mag  = (17'(fin >> 16) > SIN_ONE) ? SIN_ONE : 17'(fin >> 16);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q[0]  <= ang_i[ANGLE_BITS-1:ANGLE_BITS-2];
      x_q[0]  <= x0;
      x2_q[0] <= 17'(sq >> 16);
      t_q[0]  <= SIN_C4;
      for (int k = 1; k < SIN_LAT - 1; k++) begin
        q_q[k]  <= q_q[k-1];
        x_q[k]  <= x_q[k-1];
        x2_q[k] <= x2_q[k-1];
      end
      t_q[1] <= horner(SIN_C3, t_q[0], x2_q[0]);
      t_q[2] <= horner(SIN_C2, t_q[1], x2_q[1]);
      t_q[3] <= horner(SIN_C1, t_q[2], x2_q[2]);
      t_q[4] <= horner(SIN_C0, t_q[3], x2_q[3]);
      res_q  <= q_q[SIN_LAT-2][1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign sin_o = res_q;

endmodule

>>> rtl/uvs_back.sv
// ----------------------------------------------------------------------------
// uvs_back
// Angle division, sine/cosine, radius and theta products, rounding and
// off-grid zeroing; drives the output register.
// ----------------------------------------------------------------------------
module uvs_back import uvs_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned NUM_W      = COUNT_BITS + ANGLE_BITS + 2,
  parameter int unsigned DEN_W      = COUNT_BITS + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              deq_valid_i,
  output logic              pop_o,
  input  mesh_t             deq_mesh_i,
  input  logic [NUM_W-1:0]  num_phi_i,
  input  logic [DEN_W-1:0]  den_phi_i,
  input  logic [NUM_W-1:0]  num_th_i,
  input  logic [DEN_W-1:0]  den_th_i,
  input  logic [15:0]       radius_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [16:0]       pos_x_o,
  output logic [16:0]       pos_y_o,
  output logic [16:0]       pos_z_o,
  output mesh_t             out_mesh_o
);

  localparam int unsigned QB = ANGLE_BITS + 1;
  localparam int unsigned DL = QB + SIN_LAT;

  logic en;
  logic out_v_q;

  assign en    = !out_v_q || out_ready_i;
  assign pop_o = en;

  logic [QB-1:0]         quo_phi, quo_th;
  logic [ANGLE_BITS-1:0] phi, theta, phi_c, theta_c;

  uvs_div #(.QB(QB), .NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_phi (
    .clk_i, .en_i(en), .num_i(num_phi_i), .den_i(den_phi_i), .quo_o(quo_phi)
  );
  uvs_div #(.QB(QB), .NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_th (
    .clk_i, .en_i(en), .num_i(num_th_i), .den_i(den_th_i), .quo_o(quo_th)
  );

  always_comb begin
    phi     = ANGLE_BITS'((QB'(1) << (ANGLE_BITS - 2)) - quo_phi);
    theta   = quo_th[ANGLE_BITS-1:0];
    // cos(a) = sin(a + quarter turn)
    phi_c   = phi + (ANGLE_BITS'(1) << (ANGLE_BITS - 2));
    theta_c = theta + (ANGLE_BITS'(1) << (ANGLE_BITS - 2));
  end

  logic signed [17:0] sin_phi, cos_phi, sin_th, cos_th;

  uvs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_phi (
    .clk_i, .en_i(en), .ang_i(phi), .sin_o(sin_phi));
  uvs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cos_phi (
    .clk_i, .en_i(en), .ang_i(phi_c), .sin_o(cos_phi));
  uvs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin_th (
    .clk_i, .en_i(en), .ang_i(theta), .sin_o(sin_th));
  uvs_sin #(.ANGLE_BITS(ANGLE_BITS)) u_cos_th (
    .clk_i, .en_i(en), .ang_i(theta_c), .sin_o(cos_th));

  // sideband delay line alongside divider and sine stages
  logic  dl_v_q    [DL];
  mesh_t dl_mesh_q [DL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DL; k++) dl_v_q[k] <= 1'b0;
    end else if (en) begin
      dl_v_q[0] <= deq_valid_i;
      for (int k = 1; k < DL; k++) dl_v_q[k] <= dl_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_mesh_q[0] <= deq_mesh_i;
      for (int k = 1; k < DL; k++) dl_mesh_q[k] <= dl_mesh_q[k-1];
    end
  end

  // radius scaling, then theta products
  logic               m1_v_q, m2_v_q;
  mesh_t              m1_mesh_q, m2_mesh_q, out_mesh_q;
  logic signed [34:0] m1_y_q, m1_xz_q, m2_y_q;
  logic signed [17:0] m1_sth_q, m1_cth_q;
  logic signed [52:0] m2_x_q, m2_z_q;
  logic signed [16:0] rad_s;

  assign rad_s = $signed({1'b0, radius_i});

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_mesh_q <= dl_mesh_q[DL-1];
      m1_y_q    <= 35'(rad_s * sin_phi);
      m1_xz_q   <= 35'(rad_s * cos_phi);
      m1_sth_q  <= sin_th;
      m1_cth_q  <= cos_th;
      m2_mesh_q <= m1_mesh_q;
      m2_y_q    <= m1_y_q;
      m2_x_q    <= 53'(m1_xz_q * m1_sth_q);
      m2_z_q    <= 53'(m1_xz_q * m1_cth_q);
    end
  end

  // round half away from zero
  logic [34:0] y_mag;
  logic [52:0] x_mag, z_mag;
  logic [16:0] y_r, x_r, z_r, y_d, x_d, z_d;

  always_comb begin
    y_mag = m2_y_q[34] ? 35'(-m2_y_q) : 35'(m2_y_q);
    x_mag = m2_x_q[52] ? 53'(-m2_x_q) : 53'(m2_x_q);
    z_mag = m2_z_q[52] ? 53'(-m2_z_q) : 53'(m2_z_q);
    y_r   = 17'((y_mag + (35'(1) << 15)) >> 16);
    x_r   = 17'((x_mag + (53'(1) << 31)) >> 32);
    z_r   = 17'((z_mag + (53'(1) << 31)) >> 32);
    y_d   = m2_y_q[34] ? -y_r : y_r;
    x_d   = m2_x_q[52] ? -x_r : x_r;
    z_d   = m2_z_q[52] ? -z_r : z_r;
    if (!m2_mesh_q.grid) begin
      y_d = '0;
      x_d = '0;
      z_d = '0;
    end
  end

  logic [16:0] pos_x_q, pos_y_q, pos_z_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_q    <= x_d;
      pos_y_q    <= y_d;
      pos_z_q    <= z_d;
      out_mesh_q <= m2_mesh_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q  <= dl_v_q[DL-1];
      m2_v_q  <= m1_v_q;
      out_v_q <= m2_v_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign pos_z_o     = pos_z_q;
  assign out_mesh_o  = out_mesh_q;

  a_off_grid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_mesh_q.grid |->
      pos_x_q == '0 && pos_y_q == '0 && pos_z_q == '0)
    else $error("off-grid beat with nonzero position");

  a_no_tri_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_mesh_q.has_tri |->
      out_mesh_q.a1 == '0 && out_mesh_q.b1 == '0 && out_mesh_q.a2 == '0)
    else $error("triangle indices without a grid square");

  a_tri_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_mesh_q.has_tri |-> out_mesh_q.grid)
    else $error("grid square outside grid");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(m2_v_q) && $stable(m1_v_q))
    else $error("pipeline moved while stalled");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the UV sphere tessellator: grid points are streamed in, and every
// output beat is compared field by field with a local fixed-point model.
// ----------------------------------------------------------------------------
module testbench import uvs_pkg::*;;

  localparam int unsigned ABITS = 16;
  localparam longint unsigned FULL = 64'd1 << ABITS;
  localparam longint unsigned QUART = FULL >> 2;
  localparam int unsigned LATENCY = ABITS + 10;
  localparam int unsigned WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [16:0] px;
    logic [16:0] py;
    logic [16:0] pz;
    logic        grid;
    logic        has_tri;
    logic [15:0] a0;
    logic [15:0] a1;
    logic [15:0] a2;
    logic [15:0] b0;
    logic [15:0] b1;
    logic [15:0] b2;
  } vertex_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = 2'd0;
  logic [15:0]  cfg_wdata_i = 16'd0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = 16'd0;  // stack_index[7:0], sector_index[15:8]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // pos_x, pos_y, pos_z, tri_a0..tri_b2, zeros
  logic [151:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;          // in_grid[0], cell_valid[1]

  uv_sphere_tessellator uut (.*);

  always #5 clk_i = ~clk_i;

  longint unsigned radius_q = 256, stacks_q = 18, sectors_q = 36;
  vertex_t expected_q[$];
  int errors = 0;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  int hold_rx = 0;
  int idle_cycles = 0;

  function automatic longint fx_sine(longint unsigned ang);
    longint unsigned q, p, x, x2, t;
    ang &= FULL - 1;
    q = (ang >> (ABITS - 2)) & 3;
    p = ang & (QUART - 1);
    x = (p << 18) >> ABITS;
    if (q[0]) x = 65536 - x;
    x2 = (x * x) >> 16;
    t = 11;
    t = 307 - ((t * x2) >> 16);
    t = 5223 - ((t * x2) >> 16);
    t = 42334 - ((t * x2) >> 16);
    t = 102944 - ((t * x2) >> 16);
    t = (t * x) >> 16;
    if (t > 65536) t = 65536;
    return q[1] ? -longint'(t) : longint'(t);
  endfunction

  function automatic longint round_off(longint v, int sh);
    longint unsigned half;
    half = 64'd1 << (sh - 1);
    if (v < 0) return -$signed(($unsigned(-v) + half) >> sh);
    return $signed(($unsigned(v) + half) >> sh);
  endfunction

  function automatic vertex_t sphere_vertex(longint unsigned i, longint unsigned j);
    vertex_t v;
    longint unsigned s, n, dphi, phi, theta, row, here, below;
    longint xz;
    v = '0;
    s = (stacks_q == 0) ? 1 : stacks_q;
    n = (sectors_q == 0) ? 1 : sectors_q;
    if (i <= s && j <= n) begin
      dphi = (2 * i * FULL + s) / (4 * s);
      phi = (QUART - dphi) & (FULL - 1);
      theta = ((2 * j * FULL + n) / (2 * n)) & (FULL - 1);
      v.py = 17'(round_off(longint'(radius_q) * fx_sine(phi), 16));
      xz = longint'(radius_q) * fx_sine(phi + QUART);
      v.px = 17'(round_off(xz * fx_sine(theta), 32));
      v.pz = 17'(round_off(xz * fx_sine(theta + QUART), 32));
      v.grid = 1'b1;
    end
    if (i < s && j < n) begin
      row = n + 1;
      here = i * row + j;
      below = (i + 1) * row + j;
      v.has_tri = 1'b1;
      v.a0 = 16'(below);
      v.a1 = 16'(here);
      v.a2 = 16'(here + 1);
      v.b0 = 16'(below);
      v.b1 = 16'(below + 1);
      v.b2 = 16'(here + 1);
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // tvalid stays up after a beat; it drops only when the sender idles
  task automatic send_point(int unsigned i, int unsigned j);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {j[7:0], i[7:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q = {expected_q, sphere_vertex(i, j)};
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[15:0];
    case (idx)
      CFG_RADIUS:  radius_q = val & 16'hFFFF;
      CFG_STACKS:  stacks_q = val & 8'hFF;
      default:     sectors_q = val & 8'hFF;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // receiver side
  always @(posedge clk_i) begin
    if (hold_rx > 0) begin
      hold_rx <= hold_rx - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    vertex_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.px      = m_axis_tdata[16:0];
      got.py      = m_axis_tdata[33:17];
      got.pz      = m_axis_tdata[50:34];
      got.grid    = m_axis_tuser[0];
      got.has_tri = m_axis_tuser[1];
      got.a0      = m_axis_tdata[66:51];
      got.a1      = m_axis_tdata[82:67];
      got.a2      = m_axis_tdata[98:83];
      got.b0      = m_axis_tdata[114:99];
      got.b1      = m_axis_tdata[130:115];
      got.b2      = m_axis_tdata[146:131];
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.px != want.px) report_mismatch("pos_x", got.px, want.px);
        if (got.py != want.py) report_mismatch("pos_y", got.py, want.py);
        if (got.pz != want.pz) report_mismatch("pos_z", got.pz, want.pz);
        if (got.grid != want.grid) report_mismatch("in_grid", got.grid, want.grid);
        if (got.has_tri != want.has_tri)
          report_mismatch("cell_valid", got.has_tri, want.has_tri);
        if (got.a0 != want.a0) report_mismatch("tri_a0", got.a0, want.a0);
        if (got.a1 != want.a1) report_mismatch("tri_a1", got.a1, want.a1);
        if (got.a2 != want.a2) report_mismatch("tri_a2", got.a2, want.a2);
        if (got.b0 != want.b0) report_mismatch("tri_b0", got.b0, want.b0);
        if (got.b1 != want.b1) report_mismatch("tri_b1", got.b1, want.b1);
        if (got.b2 != want.b2) report_mismatch("tri_b2", got.b2, want.b2);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_point(0, 0);
    send_point(18, 36);
    send_point(18, 0);
    send_point(9, 9);
    send_point(17, 35);
    send_point(19, 0);
    send_point(0, 37);
    send_point(255, 255);
    send_point(170, 85);
    send_point(85, 170);
    drain();
    write_reg(CFG_RADIUS, 16'hFFFF);
    write_reg(CFG_STACKS, 255);
    write_reg(CFG_SECTORS, 255);
    send_point(0, 0);
    send_point(255, 255);
    send_point(128, 64);
    send_point(254, 254);
    send_point(127, 191);
    drain();
    // zero counts act as one
    write_reg(CFG_RADIUS, 0);
    write_reg(CFG_STACKS, 0);
    write_reg(CFG_SECTORS, 0);
    send_point(0, 0);
    send_point(1, 1);
    send_point(2, 1);
    drain();
    write_reg(CFG_STACKS, 1);
    write_reg(CFG_SECTORS, 1);
    write_reg(CFG_RADIUS, 256);
    send_point(0, 0);
    send_point(1, 1);
    send_point(0, 1);
    drain();
  endtask

  task automatic test_random(int count);
    int unsigned s, n;
    repeat (count / 100) begin
      write_reg(CFG_RADIUS, $urandom_range(3) == 0 ? 16'hFFFF : $urandom_range(65535));
      write_reg(CFG_STACKS, $urandom_range(4) == 0 ? 255 : $urandom_range(1, 40));
      write_reg(CFG_SECTORS, $urandom_range(4) == 0 ? 255 : $urandom_range(1, 40));
      s = 32'((stacks_q == 0) ? 1 : stacks_q);
      n = 32'((sectors_q == 0) ? 1 : sectors_q);
      repeat (100) begin
        if ($urandom_range(9) == 0)
          send_point($urandom_range(255), $urandom_range(255));
        else
          send_point($urandom_range(s), $urandom_range(n));
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    fork
      hold_rx = 400;
      repeat (60) send_point($urandom_range(18), $urandom_range(36));
    join
    drain();
    // sender pauses until everything has come back
    repeat (20) send_point($urandom_range(18), $urandom_range(36));
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) send_point($urandom_range(18), $urandom_range(36));
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    tx_idle_pct = 6; rx_idle_pct = 70;
    test_random(700);
    tx_idle_pct = 70; rx_idle_pct = 6;
    test_random(600);
    tx_idle_pct = 0; rx_idle_pct = 0;
    test_random(600);
    test_backpressure();
    if (errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/uvs_pkg.sv
rtl/uvs_front.sv
rtl/uvs_div.sv
rtl/uvs_sin.sv
rtl/uvs_back.sv
rtl/uv_sphere_tessellator.sv
sim/testbench.sv
